[hdl/thermistor_table_linearizer_assert.svh]
// Assertion macros for the thermistor linearizer checker
`ifndef THERMISTOR_TABLE_LINEARIZER_ASSERT_SVH
`define THERMISTOR_TABLE_LINEARIZER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TLIN_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("tlin check failed");

// Check a condition on every result item that is shown.
`define TLIN_ASSERT_OUT(lbl, cond) \
	`TLIN_ASSERT(lbl, out_valid |-> (cond))

`endif

[hdl/tlin_pkg.sv]
// Shared types and constants of the thermistor table linearizer
`timescale 1ns / 1ps

package tlin_pkg;

	localparam int TABLE_POINTS = 20;
	localparam int RES_W        = 17;
	localparam int TEMP_W       = 8;
	localparam int DY_W         = TEMP_W + 1;
	localparam int IDX_W        = $clog2(TABLE_POINTS - 1);
	localparam int SR_W         = 16;
	localparam int RES_OUT_W    = 26;
	localparam int NUMS_W       = 28;
	localparam int MAG_W        = 22;

	localparam logic [SR_W-1:0] SR_RESET = 16'd1000;
	localparam logic signed [TEMP_W-1:0] OUT_OF_RANGE_TEMP = -8'sd100;

	localparam logic [RES_W-1:0] RES_TAB [TABLE_POINTS] = '{
		17'd177,   17'd241,   17'd332,   17'd467,   17'd667,
		17'd973,   17'd1188,  17'd1459,  17'd1802,  17'd2238,
		17'd2796,  17'd3520,  17'd4450,  17'd5670,  17'd7280,
		17'd9420,  17'd16180, 17'd28680, 17'd52700, 17'd100000
	};

	localparam logic signed [TEMP_W-1:0] TEMP_TAB [TABLE_POINTS] = '{
		8'sd100, 8'sd90,  8'sd80,  8'sd70,  8'sd60,
		8'sd50,  8'sd45,  8'sd40,  8'sd35,  8'sd30,
		8'sd25,  8'sd20,  8'sd15,  8'sd10,  8'sd5,
		8'sd0,   -8'sd10, -8'sd20, -8'sd30, -8'sd40
	};

	// Sideband that rides along the interpolation divider
	typedef struct packed {
		logic [RES_OUT_W-1:0] rt;
		logic                 ok;
		logic                 neg;
	} interp_side_t;

endpackage

[hdl/tlin_div.sv]
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module tlin_div #(
	parameter int NUM_W  = 26,
	parameter int DEN_W  = 11,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side,
	output logic              out_valid,
	output logic [NUM_W-1:0]  quo,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [NUM_W];
	logic [DEN_W-1:0]  rem_s  [NUM_W];
	logic [NUM_W-1:0]  qn_s   [NUM_W];
	logic [DEN_W-1:0]  den_s  [NUM_W];
	logic [SIDE_W-1:0] side_s [NUM_W];

	for (genvar k = 0; k < NUM_W; k++) begin : g_stage
		logic              v_in;
		logic [DEN_W-1:0]  r_in;
		logic [NUM_W-1:0]  q_in;
		logic [DEN_W-1:0]  d_in;
		logic [SIDE_W-1:0] s_in;
		logic [DEN_W:0]    trial;
		logic [DEN_W:0]    diff;
		logic              ge;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign r_in = '0;
			assign q_in = num;
			assign d_in = den;
			assign s_in = side;
		end else begin : g_next
			assign v_in = vld_s[k-1];
			assign r_in = rem_s[k-1];
			assign q_in = qn_s[k-1];
			assign d_in = den_s[k-1];
			assign s_in = side_s[k-1];
		end

		// shift in the next numerator bit, subtract when it fits
		assign trial = {r_in, q_in[NUM_W-1]};
		assign ge    = trial >= {1'b0, d_in};
		assign diff  = trial - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				qn_s[k]   <= {q_in[NUM_W-2:0], ge};
				den_s[k]  <= d_in;
				side_s[k] <= s_in;
			end
		end
	end

	assign out_valid = vld_s[NUM_W-1];
	assign quo       = qn_s[NUM_W-1];
	assign out_side  = side_s[NUM_W-1];

endmodule

[hdl/tlin_seg.sv]
// Segment search and interpolation numerator, four register stages
`timescale 1ns / 1ps

module tlin_seg import tlin_pkg::*; #(
	parameter int RT_W = 26
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [RT_W-1:0]    rt,
	output logic               out_valid,
	output logic [MAG_W-1:0]   mag,
	output logic [RES_W-1:0]   dx,
	output interp_side_t       side
);

	// stage 1: segment index
	logic [IDX_W-1:0] idx_c;
	logic             ok_c;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             ok_s1;
	logic [RT_W-1:0]  rt_s1;

	always_comb begin
		idx_c = '0;
		for (int i = 1; i < TABLE_POINTS - 1; i++) begin
			if (rt > RT_W'(RES_TAB[i])) begin
				idx_c = IDX_W'(i);
			end
		end
		ok_c = (rt > RT_W'(RES_TAB[0])) && (rt <= RT_W'(RES_TAB[TABLE_POINTS-1]));
	end

	// stage 2: segment end points
	logic [IDX_W-1:0]        idx_nx;
	logic                    vld_s2;
	logic [RES_W-1:0]        dx_s2;
	logic [RES_W-1:0]        off_s2;
	logic signed [TEMP_W-1:0] y1_s2;
	logic signed [DY_W-1:0]  dy_s2;
	logic                    ok_s2;
	logic [RES_OUT_W-1:0]    rt_s2;

	assign idx_nx = idx_s1 + IDX_W'(1);

	// stage 3: products
	logic                     vld_s3;
	logic signed [NUMS_W-1:0] base_c;
	logic signed [NUMS_W-1:0] part_c;
	logic signed [NUMS_W-1:0] base_s3;
	logic signed [NUMS_W-1:0] part_s3;
	logic [RES_W-1:0]         dx_s3;
	logic                     ok_s3;
	logic [RES_OUT_W-1:0]     rt_s3;

	assign base_c = y1_s2 * $signed({1'b0, dx_s2});
	assign part_c = dy_s2 * $signed({1'b0, off_s2});

	// stage 4: sum, sign and magnitude
	logic signed [NUMS_W-1:0] num_c;
	logic [NUMS_W-1:0]        mag_c;
	logic                     vld_s4;
	logic [MAG_W-1:0]         mag_s4;
	logic [RES_W-1:0]         dx_s4;
	interp_side_t             side_s4;

	assign num_c = base_s3 + part_s3;
	assign mag_c = num_c[NUMS_W-1] ? -num_c : num_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= idx_c;
			ok_s1  <= ok_c;
			rt_s1  <= rt;

			dx_s2  <= RES_TAB[idx_nx] - RES_TAB[idx_s1];
			off_s2 <= rt_s1[RES_W-1:0] - RES_TAB[idx_s1];
			y1_s2  <= TEMP_TAB[idx_s1];
			dy_s2  <= DY_W'(TEMP_TAB[idx_nx]) - DY_W'(TEMP_TAB[idx_s1]);
			ok_s2  <= ok_s1;
			rt_s2  <= RES_OUT_W'(rt_s1);

			base_s3 <= base_c;
			part_s3 <= part_c;
			dx_s3   <= dx_s2;
			ok_s3   <= ok_s2;
			rt_s3   <= rt_s2;

			mag_s4      <= mag_c[MAG_W-1:0];
			dx_s4       <= dx_s3;
			side_s4.rt  <= rt_s3;
			side_s4.ok  <= ok_s3;
			side_s4.neg <= num_c[NUMS_W-1];
		end
	end

	assign out_valid = vld_s4;
	assign mag       = mag_s4;
	assign dx        = dx_s4;
	assign side      = side_s4;

endmodule

[hdl/thermistor_table_linearizer.sv]
// Top level of the thermistor table linearizer pipeline
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------------------
//  input   | in_valid / in_stall     | adc_code
//  output  | out_valid / out_stall   | temperature_c, resistance_ohms, in_range
//  config  | cfg_we                  | cfg_wdata (series_resistance)
//
// One item enters per cycle while in_stall is low; the two dividers resolve
// one quotient bit per stage.
// Reset clears all valid bits and loads series_resistance with 1000.
// A stalled result holds the whole pipeline; in_stall rises only then.
`timescale 1ns / 1ps

module thermistor_table_linearizer import tlin_pkg::*; #(
	parameter int ADC_BITS = 10
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [SR_W-1:0]          cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [ADC_BITS-1:0]      adc_code,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [TEMP_W-1:0] temperature_c,
	output logic [RES_OUT_W-1:0]     resistance_ohms,
	output logic                     in_range
);

	localparam int RT_W  = SR_W + ADC_BITS;
	localparam int DEN_W = ADC_BITS + 1;
	localparam logic [DEN_W-1:0] FULL_SCALE = {1'b1, {ADC_BITS{1'b0}}};
	localparam int SIDE_W = $bits(interp_side_t);

	logic [SR_W-1:0] sr_q;
	logic            en;

	// Advance everything unless a finished item waits at the output.
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_q <= SR_RESET;
		end else if (cfg_we) begin
			sr_q <= cfg_wdata;
		end
	end

	// Stage 1: divider numerator R*code and denominator full scale minus code.
	logic             vld_s1;
	logic [RT_W-1:0]  prod_s1;
	logic [DEN_W-1:0] den_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= RT_W'(sr_q) * RT_W'(adc_code);
			den_s1  <= FULL_SCALE - DEN_W'(adc_code);
		end
	end

	// Resistance divider: one quotient bit per stage.
	logic            rt_valid;
	logic [RT_W-1:0] rt;

	tlin_div #(
		.NUM_W  (RT_W),
		.DEN_W  (DEN_W),
		.SIDE_W (1)
	) u_rt_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.num       (prod_s1),
		.den       (den_s1),
		.side      (1'b0),
		.out_valid (rt_valid),
		.quo       (rt),
		.out_side  ()
	);

	// Find the segment and form |numerator| of the interpolation.
	logic             seg_valid;
	logic [MAG_W-1:0] seg_mag;
	logic [RES_W-1:0] seg_dx;
	interp_side_t     seg_side;

	tlin_seg #(
		.RT_W (RT_W)
	) u_seg (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rt_valid),
		.rt        (rt),
		.out_valid (seg_valid),
		.mag       (seg_mag),
		.dx        (seg_dx),
		.side      (seg_side)
	);

	// Interpolation divider: |num| / dx, sign reapplied afterwards so the
	// quotient truncates toward zero.
	logic             tq_valid;
	logic [MAG_W-1:0] tq;
	interp_side_t     tq_side;

	tlin_div #(
		.NUM_W  (MAG_W),
		.DEN_W  (RES_W),
		.SIDE_W (SIDE_W)
	) u_t_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (seg_valid),
		.num       (seg_mag),
		.den       (seg_dx),
		.side      (seg_side),
		.out_valid (tq_valid),
		.quo       (tq),
		.out_side  (tq_side)
	);

	// Output register: sign the quotient, substitute the out-of-range code.
	logic [TEMP_W-1:0] tq_lo;
	logic [TEMP_W-1:0] t_signed;
	logic              out_valid_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [RES_OUT_W-1:0]     res_q;
	logic                     ok_q;

	assign tq_lo    = tq[TEMP_W-1:0];
	assign t_signed = tq_side.neg ? -tq_lo : tq_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= tq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			temp_q <= tq_side.ok ? $signed(t_signed) : OUT_OF_RANGE_TEMP;
			res_q  <= tq_side.rt;
			ok_q   <= tq_side.ok;
		end
	end

	assign out_valid       = out_valid_q;
	assign temperature_c   = temp_q;
	assign resistance_ohms = res_q;
	assign in_range        = ok_q;

endmodule

[hdl/tlin_chk.sv]
// Port-level checker for the thermistor table linearizer, bound to the top
`timescale 1ns / 1ps
`include "thermistor_table_linearizer_assert.svh"

module tlin_chk import tlin_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic signed [TEMP_W-1:0] temperature_c,
	input logic [RES_OUT_W-1:0]     resistance_ohms,
	input logic                     in_range
);

	// hold a stalled result
	`TLIN_ASSERT(a_out_hold, (out_valid && out_stall) |=> (out_valid && $stable(temperature_c) && $stable(resistance_ohms) && $stable(in_range)))
	// never push back on the input while the output is empty
	`TLIN_ASSERT(a_no_idle_stall, !out_valid |-> !in_stall)
	// out-of-range items carry the fixed temperature code
	`TLIN_ASSERT_OUT(a_oor_code, in_range || (temperature_c == OUT_OF_RANGE_TEMP))
	// in-range items sit inside the table span in both fields
	`TLIN_ASSERT_OUT(a_span, !in_range || (resistance_ohms > 26'd177 && resistance_ohms <= 26'd100000 && temperature_c >= -8'sd40 && temperature_c <= 8'sd100))

endmodule

bind thermistor_table_linearizer tlin_chk u_tlin_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.temperature_c   (temperature_c),
	.resistance_ohms (resistance_ohms),
	.in_range        (in_range)
);
